[rtl/exif_pkg.sv]
// ----------------------------------------------------------------------------
// EXIF orientation parser package
// Parse phases, tag constants and the segment signature.
// ----------------------------------------------------------------------------
package exif_pkg;

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_ORDER  = 4'd1,
    PH_MARK   = 4'd2,
    PH_OFFSET = 4'd3,
    PH_SKIP   = 4'd4,
    PH_COUNT  = 4'd5,
    PH_ENTRY  = 4'd6,
    PH_MATCH  = 4'd7,
    PH_DONE   = 4'd8
  } phase_t;

  localparam logic [15:0] ORIENT_TAG  = 16'h0112;
  localparam logic [7:0]  TIFF_MARK   = 8'h2A;
  localparam logic [3:0]  ENTRY_LAST  = 4'd11;
  localparam logic [15:0] MAX_ORIENT  = 16'd8;
  localparam logic [15:0] BODY_HEADER = 16'd8;
  localparam logic [15:0] SEG_HEADER  = 16'd6;
  localparam logic [15:0] POS_MAX     = 16'hFFFF;
  localparam logic [7:0]  CHAR_I      = 8'h49;
  localparam logic [7:0]  CHAR_M      = 8'h4D;

  // Bytes of the "Exif\0\0" header.
  function automatic logic [7:0] exif_sig(input logic [2:0] idx);
    logic [7:0] s;
    case (idx)
      3'd0:    s = 8'h45;
      3'd1:    s = 8'h78;
      3'd2:    s = 8'h69;
      3'd3:    s = 8'h66;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

[rtl/exif_orientation_parser_top.sv]
// ----------------------------------------------------------------------------
// EXIF orientation parser
// Scans an EXIF APP1 segment byte by byte and reports the orientation tag.
// ----------------------------------------------------------------------------
// The block takes one segment byte per cycle while in_stall is low and gives
// one result per segment, on the transaction that carries last_byte: the
// orientation 1 to 8, or 0 when the segment is malformed, too short or has no
// valid orientation entry. Every byte updates the parse state as it is
// accepted, so a new byte is accepted in every cycle that in_stall is low; the
// result is registered in the output register. A second output stage holds a
// result while the output is stalled, so input stalls only once both are full.
module exif_orientation_parser_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] orientation
);

  logic [15:0]           byte_position, byte_position_next;
  exif_pkg::phase_t      parse_phase, parse_phase_next;
  logic                  big_endian, big_endian_next;
  logic [15:0]           ifd_start, ifd_start_next;
  logic [15:0]           entries_left, entries_left_next;
  logic [3:0]            entry_byte_index, entry_byte_index_next;
  logic [15:0]           tag_assembly, tag_assembly_next;
  logic [3:0]            found_value, found_value_next;
  logic                  failed_flag, failed_flag_next;

  logic                  accept;
  logic                  result_fire;
  logic [3:0]            result_value;
  logic                  skid_valid;
  logic [3:0]            skid_value;

  logic [15:0]           p;
  logic [15:0]           k;
  logic                  do_fail;

  function automatic logic [15:0] assemble(input logic first, input logic [7:0] b,
                                           input logic be, input logic [15:0] ta);
    logic [15:0] r;
    if (first) begin
      r = be ? {b, 8'h00} : {8'h00, b};
    end else begin
      r = ta | (be ? {8'h00, b} : {b, 8'h00});
    end
    return r;
  endfunction

  assign accept      = in_valid && !in_stall;
  assign result_fire = accept && last_byte;
  assign in_stall    = skid_valid;

  assign p = byte_position - exif_pkg::SEG_HEADER;
  assign k = p - 16'd4;

  always_comb begin
    byte_position_next    = byte_position;
    parse_phase_next      = parse_phase;
    big_endian_next       = big_endian;
    ifd_start_next        = ifd_start;
    entries_left_next     = entries_left;
    entry_byte_index_next = entry_byte_index;
    tag_assembly_next     = tag_assembly;
    found_value_next      = found_value;
    failed_flag_next      = failed_flag;
    do_fail               = 1'b0;

    if (parse_phase != exif_pkg::PH_DONE) begin
      if (byte_position == exif_pkg::POS_MAX) begin
        do_fail = 1'b1;
      end else begin
        case (parse_phase)
          exif_pkg::PH_HEADER: begin
            if (byte_position >= exif_pkg::SEG_HEADER ||
                data_byte != exif_pkg::exif_sig(byte_position[2:0])) begin
              do_fail = 1'b1;
            end else if (byte_position == exif_pkg::SEG_HEADER - 16'd1) begin
              parse_phase_next = exif_pkg::PH_ORDER;
            end
          end
          exif_pkg::PH_ORDER: begin
            if (p == 16'd0) begin
              if (data_byte == exif_pkg::CHAR_I) big_endian_next = 1'b0;
              else if (data_byte == exif_pkg::CHAR_M) big_endian_next = 1'b1;
              else do_fail = 1'b1;
            end else if (data_byte != (big_endian ? exif_pkg::CHAR_M : exif_pkg::CHAR_I)) begin
              do_fail = 1'b1;
            end else begin
              parse_phase_next = exif_pkg::PH_MARK;
            end
          end
          exif_pkg::PH_MARK: begin
            if (p == 16'd2) begin
              if (data_byte != (big_endian ? 8'h00 : exif_pkg::TIFF_MARK)) do_fail = 1'b1;
            end else if (data_byte != (big_endian ? exif_pkg::TIFF_MARK : 8'h00)) begin
              do_fail = 1'b1;
            end else begin
              parse_phase_next = exif_pkg::PH_OFFSET;
            end
          end
          exif_pkg::PH_OFFSET: begin
            // The upper half of the 32-bit offset must be zero.
            if ((big_endian && k < 16'd2) || (!big_endian && k >= 16'd2)) begin
              if (data_byte != 8'h00) do_fail = 1'b1;
            end else begin
              tag_assembly_next = assemble(k == (big_endian ? 16'd2 : 16'd0), data_byte,
                                           big_endian, tag_assembly);
            end
            if (k == 16'd3 && !do_fail) begin
              ifd_start_next        = tag_assembly_next;
              entry_byte_index_next = 4'd0;
              if (tag_assembly_next < exif_pkg::BODY_HEADER) do_fail = 1'b1;
              else if (tag_assembly_next == exif_pkg::BODY_HEADER)
                parse_phase_next = exif_pkg::PH_COUNT;
              else parse_phase_next = exif_pkg::PH_SKIP;
            end
          end
          exif_pkg::PH_SKIP: begin
            if (p + 16'd1 >= ifd_start) parse_phase_next = exif_pkg::PH_COUNT;
          end
          exif_pkg::PH_COUNT: begin
            tag_assembly_next = assemble(entry_byte_index == 4'd0, data_byte,
                                         big_endian, tag_assembly);
            if (entry_byte_index == 4'd0) begin
              entry_byte_index_next = 4'd1;
            end else begin
              entries_left_next     = tag_assembly_next;
              entry_byte_index_next = 4'd0;
              if (tag_assembly_next == 16'd0) do_fail = 1'b1;
              else parse_phase_next = exif_pkg::PH_ENTRY;
            end
          end
          exif_pkg::PH_ENTRY: begin
            if (entry_byte_index < 4'd2) begin
              tag_assembly_next = assemble(entry_byte_index == 4'd0, data_byte,
                                           big_endian, tag_assembly);
              if (entry_byte_index == 4'd1 && tag_assembly_next == exif_pkg::ORIENT_TAG)
                parse_phase_next = exif_pkg::PH_MATCH;
            end else if (entry_byte_index == exif_pkg::ENTRY_LAST) begin
              entries_left_next = entries_left - 16'd1;
              if (entries_left == 16'd1) do_fail = 1'b1;
            end
            entry_byte_index_next = (entry_byte_index == exif_pkg::ENTRY_LAST) ?
                                    4'd0 : entry_byte_index + 4'd1;
          end
          exif_pkg::PH_MATCH: begin
            if (entry_byte_index == 4'd8 || entry_byte_index == 4'd9)
              tag_assembly_next = assemble(entry_byte_index == 4'd8, data_byte,
                                           big_endian, tag_assembly);
            if (entry_byte_index == exif_pkg::ENTRY_LAST) begin
              found_value_next = (tag_assembly <= exif_pkg::MAX_ORIENT) ?
                                 tag_assembly[3:0] : 4'd0;
              parse_phase_next = exif_pkg::PH_DONE;
            end else begin
              entry_byte_index_next = entry_byte_index + 4'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (do_fail) begin
      failed_flag_next = 1'b1;
      found_value_next = 4'd0;
      parse_phase_next = exif_pkg::PH_DONE;
    end

    if (byte_position != exif_pkg::POS_MAX) byte_position_next = byte_position + 16'd1;
  end

  assign result_value = (!failed_flag_next && parse_phase_next == exif_pkg::PH_DONE) ?
                        found_value_next : 4'd0;

  // Parse state; the last byte of a segment returns it to the reset values.
  always_ff @(posedge clk) begin
    if (rst || result_fire) begin
      byte_position    <= 16'd0;
      parse_phase      <= exif_pkg::PH_HEADER;
      big_endian       <= 1'b0;
      ifd_start        <= 16'd0;
      entries_left     <= 16'd0;
      entry_byte_index <= 4'd0;
      tag_assembly     <= 16'd0;
      found_value      <= 4'd0;
      failed_flag      <= 1'b0;
    end else if (accept) begin
      byte_position    <= byte_position_next;
      parse_phase      <= parse_phase_next;
      big_endian       <= big_endian_next;
      ifd_start        <= ifd_start_next;
      entries_left     <= entries_left_next;
      entry_byte_index <= entry_byte_index_next;
      tag_assembly     <= tag_assembly_next;
      found_value      <= found_value_next;
      failed_flag      <= failed_flag_next;
    end
  end

  // Output register and skid stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_stall) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!result_fire) begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (result_fire) out_valid <= 1'b1;
    end else if (result_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (skid_valid) orientation <= skid_value;
      else if (result_fire) orientation <= result_value;
    end else if (!out_valid) begin
      if (result_fire) orientation <= result_value;
    end else if (result_fire) begin
      skid_value <= result_value;
    end
  end

endmodule
